// ===== design/sce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sce_pkg;

    typedef enum logic [3:0] {
        ALG_CCITT_FFFF = 4'd0,
        ALG_CCITT_ZERO = 4'd1,
        ALG_CRC16_8005 = 4'd2,
        ALG_CRC16_8408 = 4'd3,
        ALG_CCITT_WORD = 4'd4,
        ALG_FLETCHER16 = 4'd5,
        ALG_CRC32_LOW  = 4'd6,
        ALG_CRC32_HIGH = 4'd7,
        ALG_ADD_SUM    = 4'd8,
        ALG_XOR_SUM    = 4'd9,
        ALG_CRC8_1D    = 4'd10,
        ALG_INET_SUM   = 4'd11
    } t_alg;

    localparam logic [15:0] POLY_CCITT   = 16'h1021;
    localparam logic [15:0] POLY_8005    = 16'h8005;
    localparam logic [15:0] POLY_8408    = 16'h8408;
    localparam logic [31:0] POLY_CRC32   = 32'hEDB88320;
    localparam logic [7:0]  POLY_CRC8    = 8'h1D;
    localparam logic [15:0] INIT_16      = 16'hFFFF;
    localparam logic [31:0] INIT_32      = 32'hFFFFFFFF;
    localparam logic [7:0]  INIT_8       = 8'hFF;
    localparam logic [8:0]  FLETCHER_MOD = 9'd255;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] expected_value;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] running_value;
        logic [7:0]  second_sum;
        logic [7:0]  held_byte;
        logic        odd_phase;
    } t_state;

    typedef struct packed {
        logic [15:0] checksum;
        logic        matches_res;
    } t_result;

    // Eight MSB-first shifts of the CCITT polynomial.
    function automatic logic [15:0] crc16_left8(input logic [15:0] x);
        logic [15:0] c;
        c = x;
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ POLY_CCITT) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_right8(input logic [15:0] x,
                                                 input logic [15:0] poly);
        logic [15:0] c;
        c = x;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] crc32_right8(input logic [31:0] x);
        logic [31:0] c;
        c = x;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ POLY_CRC32) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] crc8_left8(input logic [7:0] x);
        logic [7:0] c;
        c = x;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ POLY_CRC8) : (c << 1);
        end
        return c;
    endfunction

    // Reduction modulo 255 of a value below three times the modulus.
    function automatic logic [7:0] mod255(input logic [8:0] x);
        logic [8:0] r;
        if (x >= (FLETCHER_MOD << 1)) begin
            r = x - (FLETCHER_MOD << 1);
        end else if (x >= FLETCHER_MOD) begin
            r = x - FLETCHER_MOD;
        end else begin
            r = x;
        end
        return r[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/sce_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sce_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] algorithm;

    modport source (output valid, output algorithm, input ready);
    modport sink (input valid, input algorithm, output ready);
endinterface

`default_nettype wire

// ===== design/sce_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sce_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] expected_value;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, output expected_value, input ready);
    modport sink (input valid, input data_byte, input first_byte,
                  input last_byte, input expected_value, output ready);
endinterface

`default_nettype wire

// ===== design/sce_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sce_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum;
    logic        matches_res;

    modport source (output valid, output checksum, output matches_res, input ready);
    modport sink (input valid, input checksum, input matches_res, output ready);
endinterface

`default_nettype wire

// ===== design/selectable_checksum_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Checksum engine over a byte stream, one of twelve algorithms.
// i_cfg writes the 4-bit algorithm select; it is always ready and should be
// written only while no byte is in flight. i_in carries one message byte per beat with
// first/last marks and, on the last beat, the expected checksum. o_res gives
// one beat per message: the 16-bit checksum and whether it matched.
// Each byte is folded into the running state combinationally, so the block
// takes one beat per clock unless a last byte waits on a stalled o_res. A result
// reaches o_res from its last byte via the input register, then the result register.
// When o_res stalls, bytes that are not last still flow into the running
// state; a last byte waits in the input register, and i_in.ready drops only
// once that register is occupied and cannot drain.
// Reset clears the algorithm select to CCITT with init 0xFFFF, the running
// state to zero and all valid flags.
module selectable_checksum_engine import sce_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sce_cfg_if.sink   i_cfg,
    sce_in_if.sink    i_in,
    sce_out_if.source o_res
);

    logic [3:0] r_alg;
    logic       r_in_valid;
    t_in_beat   r_in;
    t_state     r_state;
    logic       r_out_valid;
    t_result    r_out;

    t_state     n_state;
    t_result    n_out;
    logic       w_advance;
    logic       w_accept;

    // A byte leaves the input register unless it is a last byte facing a full,
    // stalled result register.
    assign w_advance = r_in_valid && (!r_in.last_byte || !r_out_valid || o_res.ready);
    assign w_accept  = i_in.valid && i_in.ready;

    assign i_in.ready  = !r_in_valid || w_advance;
    assign i_cfg.ready = 1'b1;

    sce_update u_update (
        .i_alg    (r_alg),
        .i_beat   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alg       <= ALG_CCITT_FFFF;
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_alg <= i_cfg.algorithm;
            end
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_state <= n_state;
            end
            if (w_advance && r_in.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.data_byte      <= i_in.data_byte;
            r_in.first_byte     <= i_in.first_byte;
            r_in.last_byte      <= i_in.last_byte;
            r_in.expected_value <= i_in.expected_value;
        end
        if (w_advance && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.checksum    = r_out.checksum;
    assign o_res.matches_res = r_out.matches_res;

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(w_advance && r_in.last_byte))
        else $error("result beat appeared without a last byte being processed");

    a_phase_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.last_byte) |=> !r_state.odd_phase)
        else $error("word phase left set after end of message");

    a_unknown_alg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.last_byte && (r_alg > ALG_INET_SUM))
        |=> (r_out_valid && (r_out.checksum == 16'h0000) && !r_out.matches_res))
        else $error("unused algorithm select produced a nonzero result");

endmodule

`default_nettype wire

// ===== design/sce_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sce_update import sce_pkg::*; (
    input  logic [3:0] i_alg,
    input  t_in_beat   i_beat,
    input  t_state     i_state,
    output t_state     o_state,
    output t_result    o_result
);

    t_state      start;
    logic [15:0] rv16;
    logic [15:0] word;
    logic [15:0] word_crc;
    logic [16:0] word_sum;
    logic [15:0] word_inet;
    logic [7:0]  fl_s1;
    logic [7:0]  fl_s2;
    logic [31:0] crc32_next;
    logic [31:0] crc32_inv;
    logic [15:0] sum;
    logic        alg_known;

    // Restart on a first beat, before the byte is folded in.
    always_comb begin
        start = i_state;
        if (i_beat.first_byte) begin
            case (i_alg)
                ALG_CCITT_FFFF, ALG_CRC16_8408, ALG_CCITT_WORD: begin
                    start.running_value = {16'h0000, INIT_16};
                end
                ALG_CRC32_LOW, ALG_CRC32_HIGH: begin
                    start.running_value = INIT_32;
                end
                ALG_CRC8_1D: begin
                    start.running_value = {24'h000000, INIT_8};
                end
                default: begin
                    start.running_value = '0;
                end
            endcase
            start.second_sum = '0;
            start.held_byte  = '0;
            start.odd_phase  = 1'b0;
        end
    end

    assign rv16 = start.running_value[15:0];

    // A held high byte pairs with this one; an odd final byte is padded with zero.
    assign word      = start.odd_phase ? {start.held_byte, i_beat.data_byte}
                                       : {i_beat.data_byte, 8'h00};
    assign word_crc  = crc16_left8(crc16_left8(rv16 ^ word));
    assign word_sum  = {1'b0, rv16} + {1'b0, word};
    assign word_inet = word_sum[15:0] + {15'd0, word_sum[16]};

    assign fl_s1 = mod255({1'b0, start.running_value[7:0]} + {1'b0, i_beat.data_byte});
    assign fl_s2 = mod255({1'b0, start.second_sum} + {1'b0, fl_s1});

    assign crc32_next = crc32_right8(start.running_value ^ {24'h000000, i_beat.data_byte});
    assign crc32_inv  = ~crc32_next;

    always_comb begin
        o_state   = start;
        sum       = '0;
        alg_known = 1'b1;
        case (i_alg)
            ALG_CCITT_FFFF, ALG_CCITT_ZERO: begin
                sum = crc16_left8(rv16 ^ {i_beat.data_byte, 8'h00});
                o_state.running_value = {16'h0000, sum};
            end
            ALG_CRC16_8005: begin
                sum = crc16_right8(rv16 ^ {8'h00, i_beat.data_byte}, POLY_8005);
                o_state.running_value = {16'h0000, sum};
            end
            ALG_CRC16_8408: begin
                sum = crc16_right8(rv16 ^ {8'h00, i_beat.data_byte}, POLY_8408);
                o_state.running_value = {16'h0000, sum};
            end
            ALG_CCITT_WORD, ALG_INET_SUM: begin
                if (start.odd_phase || i_beat.last_byte) begin
                    o_state.running_value = {16'h0000,
                        ((i_alg == ALG_CCITT_WORD) ? word_crc : word_inet)};
                    o_state.odd_phase = 1'b0;
                end else begin
                    o_state.held_byte = i_beat.data_byte;
                    o_state.odd_phase = 1'b1;
                end
                sum = (i_alg == ALG_CCITT_WORD) ? o_state.running_value[15:0]
                                                : ~o_state.running_value[15:0];
            end
            ALG_FLETCHER16: begin
                o_state.running_value = {24'h000000, fl_s1};
                o_state.second_sum    = fl_s2;
                sum = {fl_s2, fl_s1};
            end
            ALG_CRC32_LOW, ALG_CRC32_HIGH: begin
                o_state.running_value = crc32_next;
                sum = (i_alg == ALG_CRC32_LOW) ? crc32_inv[15:0] : crc32_inv[31:16];
            end
            ALG_ADD_SUM: begin
                sum = rv16 + {8'h00, i_beat.data_byte};
                o_state.running_value = {16'h0000, sum};
            end
            ALG_XOR_SUM: begin
                sum = rv16 ^ {8'h00, i_beat.data_byte};
                o_state.running_value = {16'h0000, sum};
            end
            ALG_CRC8_1D: begin
                sum = {8'h00, crc8_left8(start.running_value[7:0] ^ i_beat.data_byte)};
                o_state.running_value = {16'h0000, sum};
            end
            default: begin
                alg_known = 1'b0;
            end
        endcase
        if (i_beat.last_byte) begin
            o_state.odd_phase = 1'b0;
        end
    end

    assign o_result.checksum    = alg_known ? sum : 16'h0000;
    assign o_result.matches_res = alg_known && (sum == i_beat.expected_value);

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import sce_pkg::*;

    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_BYTES   = 550;
    localparam int MAX_REPORTS    = 10;

    // Selector codes past the last algorithm; the block gives a zero checksum there.
    localparam logic [3:0] ALG_UNUSED_LO = 4'd12;
    localparam logic [3:0] ALG_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic        is_cfg;
        logic [3:0]  alg;
        t_in_beat    beat;
        logic        typed;
        logic [15:0] typed_sum;
        logic        typed_match;
    } t_row;

    localparam int NUM_ROWS = 39;

    // Rows with a typed result carry values that follow directly from the
    // algorithm; all other rows are checked against the checksum predictor.
    localparam t_row DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        // Right after reset, with no start mark, the CRC runs from zero.
        '{1'b0, ALG_CCITT_FFFF, '{8'h00, 1'b0, 1'b1, 16'h0000}, 1'b1, 16'h0000, 1'b1},
        '{1'b0, ALG_CCITT_FFFF, '{8'hFF, 1'b1, 1'b0, 16'h0000}, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CCITT_FFFF, '{8'h00, 1'b0, 1'b1, 16'hFFFF}, 1'b0, 16'h0000, 1'b0},
        '{1'b1, ALG_CCITT_ZERO, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CCITT_ZERO, '{8'h00, 1'b1, 1'b1, 16'h0000}, 1'b1, 16'h0000, 1'b1},
        '{1'b1, ALG_CRC16_8005, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CRC16_8005, '{8'hA5, 1'b1, 1'b0, 16'h0000}, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CRC16_8005, '{8'h5A, 1'b0, 1'b1, 16'hFFFF}, 1'b0, 16'h0000, 1'b0},
        '{1'b1, ALG_CRC16_8408, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CRC16_8408, '{8'h31, 1'b1, 1'b0, 16'h0000}, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CRC16_8408, '{8'h32, 1'b0, 1'b1, 16'h1234}, 1'b0, 16'h0000, 1'b0},
        '{1'b1, ALG_CCITT_WORD, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CCITT_WORD, '{8'h12, 1'b1, 1'b0, 16'h0000}, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CCITT_WORD, '{8'h34, 1'b0, 1'b0, 16'h0000}, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CCITT_WORD, '{8'h56, 1'b0, 1'b1, 16'h0000}, 1'b0, 16'h0000, 1'b0},
        '{1'b1, ALG_FLETCHER16, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_FLETCHER16, '{8'hFF, 1'b1, 1'b1, 16'h0000}, 1'b1, 16'h0000, 1'b1},
        '{1'b1, ALG_CRC32_LOW, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CRC32_LOW, '{8'h31, 1'b1, 1'b0, 16'h0000}, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CRC32_LOW, '{8'h39, 1'b0, 1'b1, 16'hFFFF}, 1'b0, 16'h0000, 1'b0},
        '{1'b1, ALG_CRC32_HIGH, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CRC32_HIGH, '{8'hFF, 1'b1, 1'b1, 16'hFFFF}, 1'b0, 16'h0000, 1'b0},
        '{1'b1, ALG_ADD_SUM, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_ADD_SUM, '{8'hFF, 1'b1, 1'b0, 16'h0000}, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_ADD_SUM, '{8'hFF, 1'b0, 1'b1, 16'h01FE}, 1'b1, 16'h01FE, 1'b1},
        '{1'b1, ALG_XOR_SUM, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_XOR_SUM, '{8'hFF, 1'b1, 1'b1, 16'h00FF}, 1'b1, 16'h00FF, 1'b1},
        '{1'b1, ALG_CRC8_1D, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CRC8_1D, '{8'h00, 1'b1, 1'b1, 16'h0000}, 1'b0, 16'h0000, 1'b0},
        // A lone byte is padded to a zero word, so the sum complements to all ones.
        '{1'b1, ALG_INET_SUM, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_INET_SUM, '{8'h00, 1'b1, 1'b1, 16'hFFFF}, 1'b1, 16'hFFFF, 1'b1},
        '{1'b1, ALG_UNUSED_HI, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_UNUSED_HI, '{8'hAB, 1'b1, 1'b1, 16'h0000}, 1'b1, 16'h0000, 1'b0},
        '{1'b1, ALG_UNUSED_LO, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_UNUSED_LO, '{8'h00, 1'b1, 1'b1, 16'h0000}, 1'b1, 16'h0000, 1'b0},
        // The selector changes halfway through this message.
        '{1'b1, ALG_CCITT_FFFF, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CCITT_FFFF, '{8'h12, 1'b1, 1'b0, 16'h0000}, 1'b0, 16'h0000, 1'b0},
        '{1'b1, ALG_CRC32_LOW, '0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, ALG_CRC32_LOW, '{8'h34, 1'b0, 1'b1, 16'h0000}, 1'b0, 16'h0000, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    sce_cfg_if cfg_if ();
    sce_in_if  in_if ();
    sce_out_if res_if ();

    selectable_checksum_engine dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [3:0] alg_sel;
    t_state     chk_state;
    t_result    sum_queue [$];
    int         mismatches;
    int         bytes_sent;
    bit         no_gaps;

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [15:0] ccitt_shift(input logic [15:0] v, input int count);
        logic [15:0] c;
        c = v;
        for (int i = 0; i < count; i++) begin
            c = c[15] ? ((c << 1) ^ POLY_CCITT) : (c << 1);
        end
        return c;
    endfunction

    // Folds one byte into the running state and gives the checksum it would
    // finish with; has_res tells whether the byte ends a message.
    function automatic t_state fold_byte(input t_state s, input logic [3:0] alg,
                                         input t_in_beat b, output bit has_res,
                                         output t_result r);
        t_state      n;
        logic [31:0] c;
        logic [16:0] acc;
        logic [15:0] word;
        logic [15:0] sum;
        logic [7:0]  c8;
        int          s1;
        bit          known;
        n     = s;
        sum   = '0;
        known = 1'b1;
        if (b.first_byte) begin
            n = '0;
            case (alg)
                ALG_CCITT_FFFF, ALG_CRC16_8408, ALG_CCITT_WORD: n.running_value = 32'h0000_FFFF;
                ALG_CRC32_LOW, ALG_CRC32_HIGH: n.running_value = 32'hFFFF_FFFF;
                ALG_CRC8_1D: n.running_value = 32'h0000_00FF;
                default: ;
            endcase
        end
        case (alg)
            ALG_CCITT_FFFF, ALG_CCITT_ZERO: begin
                sum = ccitt_shift(n.running_value[15:0] ^ {b.data_byte, 8'h00}, 8);
                n.running_value = {16'h0000, sum};
            end
            ALG_CRC16_8005, ALG_CRC16_8408: begin
                word = n.running_value[15:0] ^ {8'h00, b.data_byte};
                for (int i = 0; i < 8; i++) begin
                    if (word[0]) begin
                        word = (word >> 1) ^ ((alg == ALG_CRC16_8005) ? POLY_8005 : POLY_8408);
                    end else begin
                        word = word >> 1;
                    end
                end
                n.running_value = {16'h0000, word};
                sum = word;
            end
            ALG_CCITT_WORD, ALG_INET_SUM: begin
                if (n.odd_phase || b.last_byte) begin
                    word = n.odd_phase ? {n.held_byte, b.data_byte} : {b.data_byte, 8'h00};
                    n.odd_phase = 1'b0;
                    if (alg == ALG_CCITT_WORD) begin
                        n.running_value = {16'h0000, ccitt_shift(n.running_value[15:0] ^ word, 16)};
                    end else begin
                        // Ones'-complement add: the carry wraps around into bit 0.
                        acc = {1'b0, n.running_value[15:0]} + {1'b0, word};
                        n.running_value = {16'h0000, acc[15:0] + {15'h0000, acc[16]}};
                    end
                end else begin
                    n.held_byte = b.data_byte;
                    n.odd_phase = 1'b1;
                end
                sum = (alg == ALG_CCITT_WORD) ? n.running_value[15:0] : ~n.running_value[15:0];
            end
            ALG_FLETCHER16: begin
                s1 = (int'(n.running_value[7:0]) + int'(b.data_byte)) % 255;
                n.second_sum = 8'((int'(n.second_sum) + s1) % 255);
                n.running_value = 32'(s1);
                sum = {n.second_sum, 8'(s1)};
            end
            ALG_CRC32_LOW, ALG_CRC32_HIGH: begin
                c = n.running_value ^ {24'h000000, b.data_byte};
                for (int i = 0; i < 8; i++) begin
                    c = c[0] ? ((c >> 1) ^ POLY_CRC32) : (c >> 1);
                end
                n.running_value = c;
                c = ~c;
                sum = (alg == ALG_CRC32_LOW) ? c[15:0] : c[31:16];
            end
            ALG_ADD_SUM: begin
                sum = n.running_value[15:0] + {8'h00, b.data_byte};
                n.running_value = {16'h0000, sum};
            end
            ALG_XOR_SUM: begin
                sum = n.running_value[15:0] ^ {8'h00, b.data_byte};
                n.running_value = {16'h0000, sum};
            end
            ALG_CRC8_1D: begin
                c8 = n.running_value[7:0] ^ b.data_byte;
                for (int i = 0; i < 8; i++) begin
                    c8 = c8[7] ? ((c8 << 1) ^ POLY_CRC8) : (c8 << 1);
                end
                n.running_value = {24'h000000, c8};
                sum = {8'h00, c8};
            end
            default: known = 1'b0;
        endcase
        has_res = b.last_byte;
        if (b.last_byte) begin
            n.odd_phase = 1'b0;
        end
        r.checksum    = known ? sum : 16'h0000;
        r.matches_res = known && (sum == b.expected_value);
        return n;
    endfunction

    task automatic report_miss(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns: %s: expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    // Offers one byte beat and waits until it is taken; valid stays high
    // afterwards so that back-to-back beats need no second assignment.
    task automatic push_byte(input t_in_beat b, input bit use_typed,
                             input t_result typed_res);
        int      gap;
        bit      has_res;
        t_result res;
        gap = draw_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid          <= 1'b1;
        in_if.data_byte      <= b.data_byte;
        in_if.first_byte     <= b.first_byte;
        in_if.last_byte      <= b.last_byte;
        in_if.expected_value <= b.expected_value;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        chk_state = fold_byte(chk_state, alg_sel, b, has_res, res);
        if (use_typed) begin
            res = typed_res;
        end
        if (has_res) begin
            sum_queue.push_back(res);
        end
        bytes_sent++;
    endtask

    // The select is changed only once all results are out and the input
    // register has had time to drain any byte that does not end a message.
    task automatic write_alg(input logic [3:0] a);
        in_if.valid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.algorithm <= a;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        alg_sel = a;
    endtask

    task automatic send_message(input int len, input int flavor);
        t_in_beat b;
        t_result  r;
        t_state   scratch;
        bit       has_res;
        for (int k = 0; k < len; k++) begin
            b.data_byte      = 8'($urandom_range(0, 255));
            b.first_byte     = (k == 0);
            b.last_byte      = (k == len - 1);
            b.expected_value = 16'($urandom_range(0, 65535));
            case (flavor)
                1: if (k == 0) b.first_byte = 1'b0;
                2: b.first_byte = ($urandom_range(0, 3) == 0);
                3: if (k == len - 1) b.last_byte = 1'b0;
                default: ;
            endcase
            // Half the messages carry their own checksum; a known algorithm then matches.
            if (b.last_byte && $urandom_range(0, 1) == 1) begin
                scratch = fold_byte(chk_state, alg_sel, b, has_res, r);
                b.expected_value = r.checksum;
            end
            push_byte(b, 1'b0, '0);
        end
    endtask

    initial begin : result_sink
        int      hold;
        int      stall;
        t_result want;
        res_if.ready <= 1'b0;
        hold = 0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                res_if.ready <= 1'b0;
            end else if (res_if.valid && res_if.ready) begin
                if (sum_queue.size() == 0) begin
                    report_miss("result beat with no message pending", 16'h0000,
                                res_if.checksum);
                end else begin
                    want = sum_queue.pop_front();
                    if (res_if.checksum !== want.checksum) begin
                        report_miss("checksum", want.checksum, res_if.checksum);
                    end
                    if (res_if.matches_res !== want.matches_res) begin
                        report_miss("match flag", {15'h0000, want.matches_res},
                                    {15'h0000, res_if.matches_res});
                    end
                end
                stall = draw_gap();
                if (stall > 0) begin
                    res_if.ready <= 1'b0;
                    hold = stall - 1;
                end
            end else if (!res_if.ready) begin
                if (hold == 0) begin
                    res_if.ready <= 1'b1;
                end else begin
                    hold--;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || (in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready)
                    || (res_if.valid && res_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int         phase;
        int         len;
        int         roll;
        logic [3:0] pick;
        rst_n                <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.data_byte      <= '0;
        in_if.first_byte     <= 1'b0;
        in_if.last_byte      <= 1'b0;
        in_if.expected_value <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.algorithm     <= '0;
        alg_sel    = ALG_CCITT_FFFF;
        chk_state  = '0;
        mismatches = 0;
        bytes_sent = 0;
        no_gaps    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (DIRECTED_ROWS[i].is_cfg) begin
                write_alg(DIRECTED_ROWS[i].alg);
            end else begin
                push_byte(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].typed,
                          {DIRECTED_ROWS[i].typed_sum, DIRECTED_ROWS[i].typed_match});
            end
        end

        bytes_sent = 0;
        phase = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            case (phase)
                0: pick = ALG_CCITT_FFFF;
                1: pick = ALG_INET_SUM;
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        pick = 4'($urandom_range(ALG_UNUSED_LO, ALG_UNUSED_HI));
                    end else begin
                        pick = 4'($urandom_range(ALG_CCITT_FFFF, ALG_INET_SUM));
                    end
                end
            endcase
            // An unterminated message from the last phase runs on under the new select.
            write_alg(pick);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(3, 8)) begin
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
                roll = $urandom_range(0, 9);
                send_message(len, (roll < 7) ? 0 : roll - 6);
            end
            phase++;
        end

        in_if.valid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
